>>> design/tsi_pkg.sv
// Shared types and constants for the teleop safety interlock.
package tsi_pkg;

  localparam int unsigned OPC_W      = 3;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OPC_W-1:0] OPC_BEAM = 3'd0;
  localparam logic [OPC_W-1:0] OPC_JOY  = 3'd1;
  localparam logic [OPC_W-1:0] OPC_MAN  = 3'd2;
  localparam logic [OPC_W-1:0] OPC_NAV  = 3'd3;
  localparam logic [OPC_W-1:0] OPC_PUB  = 3'd4;
  localparam logic [OPC_W-1:0] OPC_SLOW = 3'd5;
  localparam logic [OPC_W-1:0] OPC_SVC  = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START = 3'd0,
    CFG_WIN_END   = 3'd1,
    CFG_KEEPOUT   = 3'd2,
    CFG_SENS_MIN  = 3'd3,
    CFG_SENS_MAX  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_BEAM,
    CMD_JOY,
    CMD_MAN,
    CMD_NAV,
    CMD_PUB,
    CMD_SLOW,
    CMD_SVC,
    CMD_NOP
  } cmd_e;

  localparam logic [15:0] NEAR_FLOOR_MM = 16'd100;
  localparam logic [1:0]  HAT_UP        = 2'b01;
  localparam logic [1:0]  HAT_DOWN      = 2'b11;

  localparam int unsigned BTN_MANUAL  = 0;
  localparam int unsigned BTN_NAV     = 1;
  localparam int unsigned BTN_SAVE    = 2;
  localparam int unsigned BTN_RELEASE = 3;
  localparam int unsigned BTN_CANCEL  = 5;
  localparam int unsigned BTN_DEADMAN = 7;

  localparam logic [1:0] SAFETY_NONE = 2'd0;
  localparam logic [1:0] SAFETY_ON   = 2'd1;
  localparam logic [1:0] SAFETY_OFF  = 2'd2;
  localparam logic [1:0] GEAR_NONE   = 2'd0;
  localparam logic [1:0] GEAR_MANUAL = 2'd1;
  localparam logic [1:0] GEAR_NAV    = 2'd2;

  typedef struct packed {
    cmd_e               kind;
    logic               beam_hit;
    logic [7:0]         buttons;
    logic [1:0]         hat;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               svc;
  } cmd_t;

  // first member is the msb: fields listed from the top bit down
  typedef struct packed {
    logic               manual_mode;
    logic               stopped;
    logic               cancel_request;
    logic               save_map_request;
    logic               snapshot_request;
    logic [1:0]         gear_report;
    logic [1:0]         safety_report;
    logic signed [15:0] speed_value;
    logic               speed_valid;
    logic signed [15:0] twist_angular;
    logic signed [15:0] twist_linear;
    logic               twist_valid;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

>>> design/tsi_front.sv
// Front end: config registers, input unpacking and beam classification.
module tsi_front import tsi_pkg::*; #(
  parameter int unsigned MAX_BEAMS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [OPC_W-1:0]      in_opc_i,
  output cmd_t                  cmd_o
);

  logic [9:0]  win_start_q, win_end_q;
  logic [15:0] keepout_q, sens_min_q, sens_max_q;

  logic [9:0]  beam_index;
  logic [15:0] range_mm;
  logic        hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= 10'd180;
      win_end_q   <= 10'd360;
      keepout_q   <= 16'd1000;
      sens_min_q  <= 16'd0;
      sens_max_q  <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIN_START: win_start_q <= cfg_data_i[9:0];
        CFG_WIN_END:   win_end_q   <= cfg_data_i[9:0];
        CFG_KEEPOUT:   keepout_q   <= cfg_data_i;
        CFG_SENS_MIN:  sens_min_q  <= cfg_data_i;
        CFG_SENS_MAX:  sens_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign beam_index = in_data_i[9:0];
  assign range_mm   = in_data_i[25:10];

  assign hit = (beam_index >= win_start_q) && (beam_index < win_end_q) &&
               (32'(beam_index) < MAX_BEAMS) &&
               (range_mm >= sens_min_q) && (range_mm <= sens_max_q) &&
               (range_mm < keepout_q) && (range_mm > NEAR_FLOOR_MM);

  always_comb begin
    cmd_o.beam_hit = hit;
    cmd_o.buttons  = in_data_i[33:26];
    cmd_o.hat      = in_data_i[35:34];
    cmd_o.lin      = in_data_i[51:36];
    cmd_o.ang      = in_data_i[67:52];
    cmd_o.svc      = in_data_i[68];
    unique case (in_opc_i)
      OPC_BEAM: cmd_o.kind = CMD_BEAM;
      OPC_JOY:  cmd_o.kind = CMD_JOY;
      OPC_MAN:  cmd_o.kind = CMD_MAN;
      OPC_NAV:  cmd_o.kind = CMD_NAV;
      OPC_PUB:  cmd_o.kind = CMD_PUB;
      OPC_SLOW: cmd_o.kind = CMD_SLOW;
      OPC_SVC:  cmd_o.kind = CMD_SVC;
      default:  cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

>>> design/tsi_queue.sv
// Two-entry command queue between front end and back end.
module tsi_queue import tsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o       = cnt_q[1];
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

endmodule

>>> design/tsi_back.sv
// Back end: interlock state, velocity mux and registered result word.
module tsi_back import tsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  cmd_t head_cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic stop_q, stop_d, safe_off_q, safe_off_d, manual_q, manual_d;
  logic deadman_q, deadman_d, save_busy_q, save_busy_d, cancel_q, cancel_d;
  logic signed [15:0] lin_q, lin_d, ang_q, ang_d;
  logic out_valid_q;
  res_t res_q, res_d;
  logic fire;
  logic [7:0] btn;

  assign fire  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire;
  assign btn   = head_cmd_i.buttons;

  always_comb begin
    stop_d      = stop_q;
    safe_off_d  = safe_off_q;
    manual_d    = manual_q;
    deadman_d   = deadman_q;
    save_busy_d = save_busy_q;
    cancel_d    = cancel_q;
    lin_d       = lin_q;
    ang_d       = ang_q;
    res_d       = '0;
    unique case (head_cmd_i.kind)
      CMD_BEAM: begin
        if (head_cmd_i.beam_hit && !stop_q && !safe_off_q) begin
          stop_d = 1'b1;
          lin_d  = '0;
          ang_d  = '0;
          res_d.speed_valid      = 1'b1;
          res_d.snapshot_request = 1'b1;
        end
      end
      CMD_JOY: begin
        deadman_d = btn[BTN_DEADMAN];
        if (btn[BTN_RELEASE] && stop_q) begin
          stop_d = 1'b0;
        end else if (head_cmd_i.hat == HAT_UP && safe_off_q) begin
          safe_off_d = 1'b0;
          res_d.safety_report = SAFETY_ON;
        end else if (head_cmd_i.hat == HAT_DOWN && !safe_off_q) begin
          safe_off_d = 1'b1;
          res_d.safety_report = SAFETY_OFF;
        end else if (btn[BTN_MANUAL] && !manual_q) begin
          manual_d = 1'b1;
          res_d.gear_report = GEAR_MANUAL;
        end else if (btn[BTN_NAV] && manual_q) begin
          manual_d = 1'b0;
          res_d.gear_report = GEAR_NAV;
        end else if (btn[BTN_SAVE] && !save_busy_q) begin
          save_busy_d = 1'b1;
          res_d.save_map_request = 1'b1;
        end else if (btn[BTN_CANCEL] && !cancel_q) begin
          cancel_d = 1'b1;
        end
      end
      CMD_MAN: begin
        if (!stop_q && manual_q) begin
          lin_d = head_cmd_i.lin;
          ang_d = head_cmd_i.ang;
          res_d.speed_valid = 1'b1;
          res_d.speed_value = head_cmd_i.lin;
        end
      end
      CMD_NAV: begin
        if (!stop_q && !manual_q) begin
          if (deadman_q) begin
            lin_d = head_cmd_i.lin;
            ang_d = head_cmd_i.ang;
            res_d.speed_valid = 1'b1;
            res_d.speed_value = head_cmd_i.lin;
          end else begin
            lin_d = '0;
            ang_d = '0;
          end
        end
      end
      CMD_PUB: begin
        if (stop_q) begin
          lin_d = '0;
          ang_d = '0;
          res_d.speed_valid = 1'b1;
        end
        res_d.twist_valid = 1'b1;
      end
      CMD_SLOW: res_d.cancel_request = cancel_q;
      CMD_SVC: begin
        if (!head_cmd_i.svc) save_busy_d = 1'b0;
        else                 cancel_d    = 1'b0;
      end
      default: ;
    endcase
    res_d.twist_linear  = lin_d;
    res_d.twist_angular = ang_d;
    res_d.stopped       = stop_d;
    res_d.manual_mode   = manual_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q      <= 1'b0;
      safe_off_q  <= 1'b0;
      manual_q    <= 1'b1;
      deadman_q   <= 1'b0;
      save_busy_q <= 1'b0;
      cancel_q    <= 1'b0;
      lin_q       <= '0;
      ang_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        stop_q      <= stop_d;
        safe_off_q  <= safe_off_d;
        manual_q    <= manual_d;
        deadman_q   <= deadman_d;
        save_busy_q <= save_busy_d;
        cancel_q    <= cancel_d;
        lin_q       <= lin_d;
        ang_q       <= ang_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> design/teleop_safety_interlock.sv
// Top level of the teleop safety interlock and velocity multiplexer.
//
// Input stream: one event word per transfer. tuser carries the opcode
// (beam, joystick, manual vel, nav vel, publish tick, slow tick, service
// done); tdata carries the event payload. Every event yields exactly one
// result word on the output stream with held twist, speed report, mode
// and safety reports, service requests and the stop latch.
// Config port: cfg_we_i writes register cfg_idx_i (window start, window
// end, keepout, sensor min, sensor max) at the clock edge; the user must
// write only while idle, as the block does not enforce it. Throughput:
// one event per cycle while m_axis_tready is high; the front end classifies
// the beam against the window and limits, a two-entry queue feeds the back
// end, which updates the interlock state and loads the result register
// that m_axis reads. Receiver stall: the result register holds, the back
// end waits, the queue fills and s_axis_tready drops once it holds two
// events. Reset: config registers return to their defaults, stop latch
// clear, safety on, manual mode, held velocity zero, queue and output empty.
module teleop_safety_interlock import tsi_pkg::*; #(
  parameter int unsigned MAX_BEAMS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // beam_index, range_mm, buttons, hat_axis, lin_vel, ang_vel, which_service, pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [OPC_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // twist_valid, twist_linear, twist_angular, speed_valid, speed_value,
  // safety_report, gear_report, snapshot_request, save_map_request,
  // cancel_request, stopped, manual_mode, pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t front_cmd, head_cmd;
  logic q_full, q_head_valid, q_pop;
  res_t res;

  tsi_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_opc_i   (s_axis_tuser),
    .cmd_o      (front_cmd)
  );

  tsi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid && !q_full),
    .push_cmd_i   (front_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_cmd_o   (head_cmd)
  );

  tsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res)
  );

  assign s_axis_tready = !q_full;
  assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), res};

endmodule

>>> design/tsi_checker.sv
// Port-level checks for the teleop safety interlock, bound to the top level.
module tsi_checker import tsi_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  res_t r;
  assign r = m_axis_tdata[RES_W-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_snap_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.snapshot_request |-> r.stopped && r.speed_valid &&
      r.twist_linear == 16'sd0 && r.twist_angular == 16'sd0)
    else $error("snapshot without stop and zero twist");

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.speed_valid |-> r.speed_value == 16'sd0)
    else $error("speed value without report");

  a_stopped_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.twist_valid && r.stopped |->
      r.twist_linear == 16'sd0 && r.twist_angular == 16'sd0)
    else $error("nonzero twist published while stopped");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.safety_report != SAFETY_NONE |->
      r.gear_report == GEAR_NONE && !r.save_map_request)
    else $error("more than one joystick action in one word");

endmodule

bind teleop_safety_interlock tsi_checker u_tsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/teleop_safety_interlock_tb.sv
// Testbench for teleop_safety_interlock: a directed table, then random events, checked per field.
`timescale 1ns / 1ps

module teleop_safety_interlock_tb;
  import tsi_pkg::*;

  localparam int unsigned BEAM_LIMIT = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam logic [1:0] HAT_REST = 2'b00;
  localparam logic [1:0] HAT_NEG2 = 2'b10;

  typedef struct {
    cmd_e               op;
    logic [9:0]         beam;
    logic [15:0]        rng_mm;
    logic [7:0]         buttons;
    logic [1:0]         hat;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               svc;
  } event_t;

  typedef struct {
    event_t ev;
    bit     has_lit;
    res_t   lit;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OPC_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // interlock state as the block should hold it
  logic [9:0]         win_lo = 10'd180;
  logic [9:0]         win_hi = 10'd360;
  logic [15:0]        keepout = 16'd1000;
  logic [15:0]        sens_min = 16'd0;
  logic [15:0]        sens_max = 16'hFFFF;
  logic               estop = 1'b0;
  logic               safety_off = 1'b0;
  logic               manual_q = 1'b1;
  logic               deadman = 1'b0;
  logic               save_busy = 1'b0;
  logic               cancel_pend = 1'b0;
  logic signed [15:0] hold_lin = '0;
  logic signed [15:0] hold_ang = '0;

  res_t        expected_results[$];
  step_t       plan[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  teleop_safety_interlock #(
    .MAX_BEAMS(BEAM_LIMIT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic res_t interlock_step(event_t ev);
    res_t r;
    r = '0;
    case (ev.op)
      CMD_BEAM: begin
        if (ev.beam >= win_lo && ev.beam < win_hi && int'(ev.beam) < BEAM_LIMIT &&
            ev.rng_mm >= sens_min && ev.rng_mm <= sens_max &&
            ev.rng_mm < keepout && ev.rng_mm > NEAR_FLOOR_MM &&
            !estop && !safety_off) begin
          estop = 1'b1;
          hold_lin = '0;
          hold_ang = '0;
          r.speed_valid = 1'b1;
          r.snapshot_request = 1'b1;
        end
      end
      CMD_JOY: begin
        deadman = ev.buttons[BTN_DEADMAN];
        if (ev.buttons[BTN_RELEASE] && estop) begin
          estop = 1'b0;
        end else if (ev.hat == HAT_UP && safety_off) begin
          safety_off = 1'b0;
          r.safety_report = SAFETY_ON;
        end else if (ev.hat == HAT_DOWN && !safety_off) begin
          safety_off = 1'b1;
          r.safety_report = SAFETY_OFF;
        end else if (ev.buttons[BTN_MANUAL] && !manual_q) begin
          manual_q = 1'b1;
          r.gear_report = GEAR_MANUAL;
        end else if (ev.buttons[BTN_NAV] && manual_q) begin
          manual_q = 1'b0;
          r.gear_report = GEAR_NAV;
        end else if (ev.buttons[BTN_SAVE] && !save_busy) begin
          save_busy = 1'b1;
          r.save_map_request = 1'b1;
        end else if (ev.buttons[BTN_CANCEL] && !cancel_pend) begin
          cancel_pend = 1'b1;
        end
      end
      CMD_MAN: begin
        if (!estop && manual_q) begin
          hold_lin = ev.lin;
          hold_ang = ev.ang;
          r.speed_valid = 1'b1;
          r.speed_value = ev.lin;
        end
      end
      CMD_NAV: begin
        if (!estop && !manual_q) begin
          if (deadman) begin
            hold_lin = ev.lin;
            hold_ang = ev.ang;
            r.speed_valid = 1'b1;
            r.speed_value = ev.lin;
          end else begin
            hold_lin = '0;
            hold_ang = '0;
          end
        end
      end
      CMD_PUB: begin
        if (estop) begin
          hold_lin = '0;
          hold_ang = '0;
          r.speed_valid = 1'b1;
        end
        r.twist_valid = 1'b1;
      end
      CMD_SLOW: r.cancel_request = cancel_pend;
      CMD_SVC: begin
        if (!ev.svc) begin
          save_busy = 1'b0;
        end else begin
          cancel_pend = 1'b0;
        end
      end
      default: ;
    endcase
    r.twist_linear = hold_lin;
    r.twist_angular = hold_ang;
    r.stopped = estop;
    r.manual_mode = manual_q;
    return r;
  endfunction

  function automatic event_t evt(cmd_e op, int unsigned beam, int unsigned rng,
                                 logic [7:0] btn, logic [1:0] hat, int lin, int ang, bit svc);
    event_t e;
    e.op = op;
    e.beam = beam[9:0];
    e.rng_mm = rng[15:0];
    e.buttons = btn;
    e.hat = hat;
    e.lin = lin[15:0];
    e.ang = ang[15:0];
    e.svc = svc;
    return e;
  endfunction

  task automatic add_step(event_t ev, bit has_lit, res_t lit);
    step_t s;
    s.ev = ev;
    s.has_lit = has_lit;
    s.lit = lit;
    plan = {plan, s};
  endtask

  function automatic event_t random_event();
    event_t      e;
    int unsigned w;
    int unsigned lo;
    int unsigned hi;
    e.op = cmd_e'(3'($urandom_range(0, 7)));
    e.beam = 10'($urandom_range(0, 1023));
    e.rng_mm = 16'($urandom_range(0, 65535));
    e.buttons = 8'($urandom_range(0, 255));
    e.hat = 2'($urandom_range(0, 3));
    e.lin = 16'($urandom_range(0, 65535));
    e.ang = 16'($urandom_range(0, 65535));
    e.svc = 1'($urandom_range(0, 1));
    w = $urandom_range(0, 99);
    if (w < 35) begin
      e.op = CMD_BEAM;
      if (win_hi > win_lo && $urandom_range(0, 3) != 0) begin
        e.beam = 10'($urandom_range(win_lo, win_hi - 1));
      end
      case ($urandom_range(0, 3))
        0: e.rng_mm = 16'($urandom_range(0, 300));
        1: begin
          lo = (keepout > 64) ? keepout - 64 : 0;
          hi = (keepout < 16'hFFBF) ? keepout + 64 : 16'hFFFF;
          e.rng_mm = 16'($urandom_range(lo, hi));
        end
        2: e.rng_mm = 16'($urandom_range(sens_min, sens_max));
        default: ;
      endcase
    end else if (w < 55) begin
      e.op = CMD_JOY;
      if ($urandom_range(0, 1) != 0) begin
        e.buttons = 8'((8'd1 << $urandom_range(0, 7)) |
                       ($urandom_range(0, 1) << BTN_DEADMAN));
      end
    end else if (w < 65) begin
      e.op = CMD_MAN;
    end else if (w < 75) begin
      e.op = CMD_NAV;
    end else if (w < 87) begin
      e.op = CMD_PUB;
    end else if (w < 92) begin
      e.op = CMD_SLOW;
    end else if (w < 97) begin
      e.op = CMD_SVC;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_word(res_t got, res_t want);
    if (got.twist_valid !== want.twist_valid)
      report_mismatch("twist_valid", got.twist_valid, want.twist_valid);
    if (got.twist_linear !== want.twist_linear)
      report_mismatch("twist_linear", got.twist_linear, want.twist_linear);
    if (got.twist_angular !== want.twist_angular)
      report_mismatch("twist_angular", got.twist_angular, want.twist_angular);
    if (got.speed_valid !== want.speed_valid)
      report_mismatch("speed_valid", got.speed_valid, want.speed_valid);
    if (got.speed_value !== want.speed_value)
      report_mismatch("speed_value", got.speed_value, want.speed_value);
    if (got.safety_report !== want.safety_report)
      report_mismatch("safety_report", got.safety_report, want.safety_report);
    if (got.gear_report !== want.gear_report)
      report_mismatch("gear_report", got.gear_report, want.gear_report);
    if (got.snapshot_request !== want.snapshot_request)
      report_mismatch("snapshot_request", got.snapshot_request, want.snapshot_request);
    if (got.save_map_request !== want.save_map_request)
      report_mismatch("save_map_request", got.save_map_request, want.save_map_request);
    if (got.cancel_request !== want.cancel_request)
      report_mismatch("cancel_request", got.cancel_request, want.cancel_request);
    if (got.stopped !== want.stopped)
      report_mismatch("stopped", got.stopped, want.stopped);
    if (got.manual_mode !== want.manual_mode)
      report_mismatch("manual_mode", got.manual_mode, want.manual_mode);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("word with nothing expected", got, 0);
      end else begin
        check_word(got, expected_results.pop_front());
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic offer(event_t ev, bit has_lit, res_t lit);
    res_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ev.op;
    s_axis_tdata <= {3'b000, ev.svc, ev.ang, ev.lin, ev.hat, ev.buttons, ev.rng_mm, ev.beam};
    do @(posedge clk_i); while (!s_axis_tready);
    want = interlock_step(ev);
    if (has_lit) want = lit;
    expected_results = {expected_results, want};
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_WIN_START: win_lo = value[9:0];
      CFG_WIN_END:   win_hi = value[9:0];
      CFG_KEEPOUT:   keepout = value;
      CFG_SENS_MIN:  sens_min = value;
      CFG_SENS_MAX:  sens_max = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [9:0] ws, logic [9:0] we, logic [15:0] ko, logic [15:0] mn,
                           logic [15:0] mx, int unsigned count, bit squeeze);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk_i);
    write_reg(CFG_WIN_START, ws);
    write_reg(CFG_WIN_END, we);
    write_reg(CFG_KEEPOUT, ko);
    write_reg(CFG_SENS_MIN, mn);
    write_reg(CFG_SENS_MAX, mx);
    cfg_we_i <= 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (squeeze && i == 100) hold_off_req = 1'b1;
      offer(random_event(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIN_START;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_step(evt(CMD_PUB, 0, 0, 8'h00, HAT_REST, 0, 0, 0), 1'b1,
             res_t'{twist_valid: 1'b1, manual_mode: 1'b1, default: '0});
    add_step(evt(CMD_NOP, 1023, 65535, 8'hFF, HAT_DOWN, -1, -1, 1), 1'b1,
             res_t'{manual_mode: 1'b1, default: '0});
    add_step(evt(CMD_MAN, 0, 0, 8'h00, HAT_REST, 32767, -32768, 0), 1'b1,
             res_t'{twist_linear: 16'sh7FFF, twist_angular: 16'sh8000,
                    speed_valid: 1'b1, speed_value: 16'sh7FFF,
                    manual_mode: 1'b1, default: '0});
    add_step(evt(CMD_MAN, 0, 0, 8'h00, HAT_REST, -32768, 32767, 0), 1'b1,
             res_t'{twist_linear: 16'sh8000, twist_angular: 16'sh7FFF,
                    speed_valid: 1'b1, speed_value: 16'sh8000,
                    manual_mode: 1'b1, default: '0});
    // near floor, just outside the window on both sides
    add_step(evt(CMD_BEAM, 200, 100, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_BEAM, 179, 500, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_BEAM, 360, 500, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_BEAM, 180, 999, 8'h00, HAT_REST, 0, 0, 0), 1'b1,
             res_t'{speed_valid: 1'b1, snapshot_request: 1'b1, stopped: 1'b1,
                    manual_mode: 1'b1, default: '0});
    add_step(evt(CMD_MAN, 0, 0, 8'h00, HAT_REST, 5, 5, 0), 1'b0, '0);
    add_step(evt(CMD_PUB, 0, 0, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'hFF, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'h00, HAT_DOWN, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_BEAM, 300, 200, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'h00, HAT_UP, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'h00, HAT_NEG2, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'(1 << BTN_NAV), HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_NAV, 0, 0, 8'h00, HAT_REST, 1000, 1000, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'(1 << BTN_DEADMAN), HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_NAV, 0, 0, 8'h00, HAT_REST, -1234, 4321, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'((1 << BTN_DEADMAN) | (1 << BTN_MANUAL)),
                 HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'(1 << BTN_SAVE), HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_JOY, 0, 0, 8'(1 << BTN_CANCEL), HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_SLOW, 0, 0, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    add_step(evt(CMD_SVC, 0, 0, 8'h00, HAT_REST, 0, 0, 1), 1'b0, '0);
    add_step(evt(CMD_SVC, 0, 0, 8'h00, HAT_REST, 0, 0, 0), 1'b0, '0);
    foreach (plan[i]) offer(plan[i].ev, plan[i].has_lit, plan[i].lit);
    // sender pauses here until the block has emptied
    s_axis_tvalid <= 1'b0;
    wait_drained();

    run_phase(10'd0, 10'd1023, 16'hFFFF, 16'd0, 16'hFFFF, 300, 1'b1);
    run_phase(10'd1023, 10'd0, 16'hFFFF, 16'hFFFF, 16'd0, 300, 1'b0);
    run_phase(10'd100, 10'd200, 16'd0, 16'd0, 16'hFFFF, 300, 1'b0);
    run_phase(10'd0, 10'd1023, 16'd2000, 16'd500, 16'd1500, 300, 1'b0);
    run_phase(10'($urandom_range(0, 400)), 10'($urandom_range(300, 1023)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(1000, 65535)), 300, 1'b0);
    calm = 1'b1;
    run_phase(10'd180, 10'd360, 16'd1000, 16'd0, 16'hFFFF, 330, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tsi_pkg.sv
design/tsi_front.sv
design/tsi_queue.sv
design/tsi_back.sv
design/teleop_safety_interlock.sv
design/tsi_checker.sv
verif/teleop_safety_interlock_tb.sv
